FILE: rtl/sha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, constants and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int unsigned FIFO_DEPTH = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } sha_item_t;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS = 6'd56;

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0: k = 32'h428A2F98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hB5C0FBCF;  6'd3: k = 32'hE9B5DBA5;
            6'd4: k = 32'h3956C25B;  6'd5: k = 32'h59F111F1;
            6'd6: k = 32'h923F82A4;  6'd7: k = 32'hAB1C5ED5;
            6'd8: k = 32'hD807AA98;  6'd9: k = 32'h12835B01;
            6'd10: k = 32'h243185BE; 6'd11: k = 32'h550C7DC3;
            6'd12: k = 32'h72BE5D74; 6'd13: k = 32'h80DEB1FE;
            6'd14: k = 32'h9BDC06A7; 6'd15: k = 32'hC19BF174;
            6'd16: k = 32'hE49B69C1; 6'd17: k = 32'hEFBE4786;
            6'd18: k = 32'h0FC19DC6; 6'd19: k = 32'h240CA1CC;
            6'd20: k = 32'h2DE92C6F; 6'd21: k = 32'h4A7484AA;
            6'd22: k = 32'h5CB0A9DC; 6'd23: k = 32'h76F988DA;
            6'd24: k = 32'h983E5152; 6'd25: k = 32'hA831C66D;
            6'd26: k = 32'hB00327C8; 6'd27: k = 32'hBF597FC7;
            6'd28: k = 32'hC6E00BF3; 6'd29: k = 32'hD5A79147;
            6'd30: k = 32'h06CA6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27B70A85; 6'd33: k = 32'h2E1B2138;
            6'd34: k = 32'h4D2C6DFC; 6'd35: k = 32'h53380D13;
            6'd36: k = 32'h650A7354; 6'd37: k = 32'h766A0ABB;
            6'd38: k = 32'h81C2C92E; 6'd39: k = 32'h92722C85;
            6'd40: k = 32'hA2BFE8A1; 6'd41: k = 32'hA81A664B;
            6'd42: k = 32'hC24B8B70; 6'd43: k = 32'hC76C51A3;
            6'd44: k = 32'hD192E819; 6'd45: k = 32'hD6990624;
            6'd46: k = 32'hF40E3585; 6'd47: k = 32'h106AA070;
            6'd48: k = 32'h19A4C116; 6'd49: k = 32'h1E376C08;
            6'd50: k = 32'h2748774C; 6'd51: k = 32'h34B0BCB5;
            6'd52: k = 32'h391C0CB3; 6'd53: k = 32'h4ED8AA4A;
            6'd54: k = 32'h5B9CCA4F; 6'd55: k = 32'h682E6FF3;
            6'd56: k = 32'h748F82EE; 6'd57: k = 32'h78A5636F;
            6'd58: k = 32'h84C87814; 6'd59: k = 32'h8CC70208;
            6'd60: k = 32'h90BEFFFA; 6'd61: k = 32'hA4506CEB;
            6'd62: k = 32'hBEF9A3F7; 6'd63: k = 32'hC67178F2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

FILE: rtl/sha_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 item queue
// Short queue that decouples accepting items from processing them.
// ----------------------------------------------------------------------------
module sha_fifo
    import sha_pkg::*;
#(
    parameter int unsigned DEPTH = FIFO_DEPTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  sha_item_t      push_item,
    output logic           full,
    input  wire logic      pop,
    output sha_item_t      pop_item,
    output logic           empty
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sha_item_t        mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;

    function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full     = (count_reg == (AW+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= inc_ptr(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= inc_ptr(rd_ptr_reg);
            end
            count_reg <= count_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

endmodule
`default_nettype wire

FILE: rtl/sha_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 back end
// Gathers bytes, pads messages, runs one compression round per cycle and
// emits the digest words through an output register.
// ----------------------------------------------------------------------------
module sha_core
    import sha_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    input  sha_item_t        item,
    output logic             item_pop,
    output logic             valid,
    input  wire logic        stall,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             final_word
);
    typedef enum logic [2:0] {
        ST_TAKE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } state_t;

    // The pad byte landed too late for the length, which goes in the next block.
    localparam logic [3:0] PAD_WAIT = 4'd15;

    state_t       state_reg;
    logic [31:0]  buf_reg [16];
    logic [5:0]   fill_reg;
    logic [60:0]  total_reg;
    logic [31:0]  hash_reg [8];
    logic [31:0]  var_reg [8];
    logic [31:0]  win_reg [16];
    logic [5:0]   round_reg;
    logic         finishing_reg;
    logic [3:0]   pad_cnt_reg;
    logic [2:0]   emit_idx_reg;
    logic         valid_reg;
    logic [31:0]  word_reg;
    logic [2:0]   index_reg;
    logic         final_reg;
    logic [5:0]   load_idx_reg;

    logic [7:0]   pad_byte;
    logic [63:0]  bit_len;
    logic [31:0]  w_cur;
    logic [31:0]  w_new;
    logic [31:0]  t1;
    logic [31:0]  t2;
    logic         out_free;

    assign out_free    = !valid_reg || !stall;
    assign valid       = valid_reg;
    assign digest_word = word_reg;
    assign word_index  = index_reg;
    assign final_word  = final_reg;
    assign item_pop    = (state_reg == ST_TAKE) && item_valid;
    assign bit_len     = {total_reg, 3'b000};

    always_comb
    begin
        if (pad_cnt_reg == 4'd0)
        begin
            pad_byte = PAD_BYTE;
        end
        else if (fill_reg >= LEN_POS && pad_cnt_reg != PAD_WAIT)
        begin
            pad_byte = bit_len[8*(7 - (fill_reg - LEN_POS)) +: 8];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    always_comb
    begin
        logic [31:0] w2;
        logic [31:0] w15;
        w2    = win_reg[14];
        w15   = win_reg[1];
        w_new = (ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10)) + win_reg[9]
              + (ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3)) + win_reg[0];
        w_cur = (round_reg < 6'd16) ? win_reg[round_reg[3:0]] : w_new;
        t1 = var_reg[7] + (ror32(var_reg[4], 6) ^ ror32(var_reg[4], 11)
             ^ ror32(var_reg[4], 25)) + ((var_reg[4] & var_reg[5])
             ^ (~var_reg[4] & var_reg[6])) + round_k(round_reg) + w_cur;
        t2 = (ror32(var_reg[0], 2) ^ ror32(var_reg[0], 13) ^ ror32(var_reg[0], 22))
             + ((var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
             ^ (var_reg[1] & var_reg[2]));
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_TAKE && item_valid && item.has_byte)
        begin
            buf_reg[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] <= item.data_byte;
        end
        else if (state_reg == ST_PAD)
        begin
            buf_reg[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] <= pad_byte;
        end
        if (state_reg == ST_LOAD)
        begin
            win_reg[load_idx_reg[3:0]] <= buf_reg[load_idx_reg[3:0]];
            for (int j = 0; j < 8; j++)
            begin
                var_reg[j] <= hash_reg[j];
            end
        end
        else if (state_reg == ST_ROUND)
        begin
            if (round_reg >= 6'd16)
            begin
                for (int j = 0; j < 15; j++)
                begin
                    win_reg[j] <= win_reg[j+1];
                end
                win_reg[15] <= w_new;
            end
            var_reg[7] <= var_reg[6];
            var_reg[6] <= var_reg[5];
            var_reg[5] <= var_reg[4];
            var_reg[4] <= var_reg[3] + t1;
            var_reg[3] <= var_reg[2];
            var_reg[2] <= var_reg[1];
            var_reg[1] <= var_reg[0];
            var_reg[0] <= t1 + t2;
        end
        if (state_reg == ST_EMIT && out_free)
        begin
            word_reg  <= hash_reg[emit_idx_reg];
            index_reg <= emit_idx_reg;
            final_reg <= (emit_idx_reg == 3'd7);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_TAKE;
            fill_reg      <= '0;
            total_reg     <= '0;
            round_reg     <= '0;
            finishing_reg <= 1'b0;
            pad_cnt_reg   <= '0;
            emit_idx_reg  <= '0;
            valid_reg     <= 1'b0;
            load_idx_reg  <= '0;
            for (int j = 0; j < 8; j++)
            begin
                hash_reg[j] <= INIT_HASH[j];
            end
        end
        else
        begin
            if (valid_reg && !stall && state_reg != ST_EMIT)
            begin
                valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_TAKE:
                begin
                    if (item_valid)
                    begin
                        finishing_reg <= item.end_of_message;
                        pad_cnt_reg   <= '0;
                        if (item.has_byte)
                        begin
                            fill_reg  <= fill_reg + 6'd1;
                            total_reg <= total_reg + 61'd1;
                            if (fill_reg == 6'd63)
                            begin
                                state_reg    <= ST_LOAD;
                                load_idx_reg <= '0;
                            end
                            else if (item.end_of_message)
                            begin
                                state_reg <= ST_PAD;
                            end
                        end
                        else if (item.end_of_message)
                        begin
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_PAD:
                begin
                    fill_reg <= fill_reg + 6'd1;
                    if (pad_cnt_reg == 4'd0)
                    begin
                        pad_cnt_reg <= (fill_reg >= LEN_POS) ? PAD_WAIT : 4'd1;
                    end
                    else if (fill_reg >= LEN_POS && pad_cnt_reg != PAD_WAIT)
                    begin
                        pad_cnt_reg <= pad_cnt_reg + 4'd1;
                    end
                    if (fill_reg == 6'd63)
                    begin
                        state_reg    <= ST_LOAD;
                        load_idx_reg <= '0;
                    end
                end
                ST_LOAD:
                begin
                    load_idx_reg <= load_idx_reg + 6'd1;
                    if (load_idx_reg == 6'd15)
                    begin
                        state_reg <= ST_ROUND;
                        round_reg <= '0;
                    end
                end
                ST_ROUND:
                begin
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == 6'd63)
                    begin
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD:
                begin
                    for (int j = 0; j < 8; j++)
                    begin
                        hash_reg[j] <= hash_reg[j] + var_reg[j];
                    end
                    if (!finishing_reg)
                    begin
                        state_reg <= ST_TAKE;
                    end
                    else if (pad_cnt_reg == 4'd9)
                    begin
                        state_reg    <= ST_EMIT;
                        emit_idx_reg <= '0;
                    end
                    else
                    begin
                        state_reg <= ST_PAD;
                        if (pad_cnt_reg == PAD_WAIT)
                        begin
                            pad_cnt_reg <= 4'd1;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        valid_reg    <= 1'b1;
                        emit_idx_reg <= emit_idx_reg + 3'd1;
                        if (emit_idx_reg == 3'd7)
                        begin
                            state_reg <= ST_TAKE;
                            fill_reg  <= '0;
                            total_reg <= '0;
                            for (int j = 0; j < 8; j++)
                            begin
                                hash_reg[j] <= INIT_HASH[j];
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_TAKE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/sha256_stream_hasher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a byte stream and emits each digest as eight 32-bit words.
// ----------------------------------------------------------------------------
// A byte that neither fills a block nor ends a message is just buffered.
// A full block is loaded, compressed round by round, then added into the hash.
// Ending a message pads bytewise, emits 8 words, one a cycle unless stalled.
// A four-entry input queue accepts while the back end is busy, until full.
// Reset loads the initial hash values and clears the counts.
module sha256_stream_hasher
    import sha_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = FIFO_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        has_byte,
    input  wire logic        end_of_message,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             final_word
);
    sha_item_t in_item;
    sha_item_t q_item;
    logic      q_full;
    logic      q_empty;
    logic      q_pop;
    logic      push;

    assign in_item  = '{data_byte: data_byte, has_byte: has_byte,
                        end_of_message: end_of_message};
    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    sha_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (in_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_item),
        .empty     (q_empty)
    );

    sha_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (!q_empty),
        .item        (q_item),
        .item_pop    (q_pop),
        .valid       (out_valid),
        .stall       (out_stall),
        .digest_word (digest_word),
        .word_index  (word_index),
        .final_word  (final_word)
    );

    a_final_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (final_word == (word_index == 3'd7)))
        else $error("final_word disagrees with word_index");

    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !final_word) ##1 out_valid
        |-> word_index == $past(word_index) + 3'd1)
        else $error("digest words out of order");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

endmodule
`default_nettype wire
